/* hw/rtl/tun_pkg.sv */
`default_nettype none
package tun_pkg;

  localparam int COORD_W = 16;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int DIFF_W  = PROD_W + 1;
  localparam int MAG_W   = DIFF_W - 2;
  localparam int KEEP_W  = 30;
  localparam int SHIFT_MAX = MAG_W - KEEP_W;
  localparam int SQR_W   = 2 * KEEP_W;
  localparam int SUM_W   = SQR_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int FRAC_W  = 14;
  localparam int Q_W     = FRAC_W + 1;
  localparam int NUM_W   = KEEP_W + FRAC_W + 2;
  localparam int DEN_W   = ROOT_W + 1;
  localparam int OUT_W   = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by_coord;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
  } tun_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] nrm_x;
    logic signed [OUT_W-1:0] nrm_y;
    logic signed [OUT_W-1:0] nrm_z;
    logic                    degenerate;
  } tun_out_t;

  typedef struct packed {
    logic                  degen;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } tun_cross_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0]             neg;
    logic [2:0][KEEP_W-1:0] m;
  } tun_carry_t;

endpackage
`default_nettype wire

/* hw/rtl/triangle_unit_normal_top.sv */
`default_nettype none
// Unit face normal of a triangle: one triangle (three Q12.4 vertices) per word in, one Q2.14
// unit normal per word out, in order. The block takes a new triangle every cycle while in_full
// is low; the front registers the edges, the products and the exact cross product in turn and
// feeds a four-word queue, and the back scales, squares, runs a 31-stage square root of the
// sum of squares and a 15-stage divider for each component. A result that is not popped stalls
// the back pipeline, and the queue then fills before push is refused. A zero cross product
// gives a zero normal with the degenerate flag set.
module triangle_unit_normal_top (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire tun_pkg::tun_in_t in_word,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output tun_pkg::tun_out_t     out_word
);

  logic                q_push;
  logic                q_full;
  logic                q_pop;
  logic                q_empty;
  tun_pkg::tun_cross_t q_wdata;
  tun_pkg::tun_cross_t q_rdata;

  tun_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_wdata (q_wdata)
  );

  tun_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  tun_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_rdata   (q_rdata),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_word.degenerate) |->
      (out_word.nrm_x == '0 && out_word.nrm_y == '0 && out_word.nrm_z == '0))
    else $error("degenerate word carries a nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_word.nrm_x <= 16'sd16384 && out_word.nrm_x >= -16'sd16384 &&
                    out_word.nrm_y <= 16'sd16384 && out_word.nrm_y >= -16'sd16384 &&
                    out_word.nrm_z <= 16'sd16384 && out_word.nrm_z >= -16'sd16384))
    else $error("normal component out of unit range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_word)))
    else $error("waiting result lost or changed");
`endif

endmodule
`default_nettype wire

/* hw/rtl/tun_queue.sv */
`default_nettype none
module tun_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire tun_pkg::tun_cross_t wdata,
  input  wire logic                pop,
  output logic                     empty,
  output tun_pkg::tun_cross_t      rdata
);

  tun_pkg::tun_cross_t mem_r [tun_pkg::QUEUE_DEPTH];
  logic [tun_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [tun_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [tun_pkg::QPTR_W:0]   cnt_r;
  logic do_push;
  logic do_pop;

  assign full    = (cnt_r == (tun_pkg::QPTR_W+1)'(tun_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wdata;
  end

endmodule
`default_nettype wire

/* hw/rtl/tun_front.sv */
`default_nettype none
module tun_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire tun_pkg::tun_in_t in_word,
  output logic                  q_push,
  input  wire logic             q_full,
  output tun_pkg::tun_cross_t   q_wdata
);

  localparam int EW = tun_pkg::EDGE_W;
  localparam int PW = tun_pkg::PROD_W;
  localparam int DW = tun_pkg::DIFF_W;
  localparam int MW = tun_pkg::MAG_W;

  logic adv;
  logic v1_r, v2_r, v3_r;
  logic signed [EW-1:0] e0x_r, e0y_r, e0z_r, e1x_r, e1y_r, e1z_r;
  logic signed [PW-1:0] pa_r, pb_r, pc_r, pd_r, pe_r, pf_r;
  logic signed [DW-1:0] d0, d1, d2;
  tun_pkg::tun_cross_t cross_r;
  tun_pkg::tun_cross_t cross_nxt;

  assign adv     = !(v3_r && q_full);
  assign in_full = !adv;
  assign q_push  = v3_r;
  assign q_wdata = cross_r;

  assign d0 = DW'(pa_r) - DW'(pb_r);
  assign d1 = DW'(pc_r) - DW'(pd_r);
  assign d2 = DW'(pe_r) - DW'(pf_r);

  always_comb begin
    cross_nxt.neg    = {d2[DW-1], d1[DW-1], d0[DW-1]};
    cross_nxt.mag[0] = MW'(d0[DW-1] ? -d0 : d0);
    cross_nxt.mag[1] = MW'(d1[DW-1] ? -d1 : d1);
    cross_nxt.mag[2] = MW'(d2[DW-1] ? -d2 : d2);
    cross_nxt.degen  = (d0 == '0) && (d1 == '0) && (d2 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_push;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0x_r   <= EW'(in_word.ax) - EW'(in_word.cx);
      e0y_r   <= EW'(in_word.ay) - EW'(in_word.cy);
      e0z_r   <= EW'(in_word.az) - EW'(in_word.cz);
      e1x_r   <= EW'(in_word.bx) - EW'(in_word.cx);
      e1y_r   <= EW'(in_word.by_coord) - EW'(in_word.cy);
      e1z_r   <= EW'(in_word.bz) - EW'(in_word.cz);
      pa_r    <= PW'(e0y_r) * PW'(e1z_r);
      pb_r    <= PW'(e0z_r) * PW'(e1y_r);
      pc_r    <= PW'(e0z_r) * PW'(e1x_r);
      pd_r    <= PW'(e0x_r) * PW'(e1z_r);
      pe_r    <= PW'(e0x_r) * PW'(e1y_r);
      pf_r    <= PW'(e0y_r) * PW'(e1x_r);
      cross_r <= cross_nxt;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/tun_back.sv */
`default_nettype none
module tun_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  output logic                     q_pop,
  input  wire tun_pkg::tun_cross_t q_rdata,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output tun_pkg::tun_out_t        out_word
);

  localparam int KW = tun_pkg::KEEP_W;
  localparam int MW = tun_pkg::MAG_W;
  localparam int SW = tun_pkg::SUM_W;
  localparam int QW = tun_pkg::SQR_W;
  localparam int RW = tun_pkg::ROOT_W;
  localparam int XW = tun_pkg::REM_W;
  localparam int NW = tun_pkg::NUM_W;
  localparam int DNW = tun_pkg::DEN_W;
  localparam int QTW = tun_pkg::Q_W;
  localparam int OW = tun_pkg::OUT_W;
  localparam int FW = tun_pkg::FRAC_W;

  logic adv;

  logic v0_r, v1_r, v2_r;
  tun_pkg::tun_cross_t x0_r;
  tun_pkg::tun_carry_t c1_r, c2_r;
  tun_pkg::tun_carry_t c1_nxt;
  logic [MW-1:0] or_mag;
  logic [$clog2(tun_pkg::SHIFT_MAX+1)-1:0] shift_amt;
  logic [2:0][QW-1:0] sq_r;

  logic                sv_r   [RW+1];
  logic [SW-1:0]       ss_r   [RW+1];
  logic [XW-1:0]       rem_r  [RW+1];
  logic [RW-1:0]       root_r [RW+1];
  tun_pkg::tun_carry_t sc_r   [RW+1];

  logic                dv_r   [QTW+1];
  logic [2:0][NW-1:0]  dn_r   [QTW+1];
  logic [2:0][QTW-1:0] dq_r   [QTW+1];
  logic [DNW-1:0]      dd_r   [QTW+1];
  tun_pkg::tun_carry_t dc_r   [QTW+1];

  logic                out_v_r;
  tun_pkg::tun_out_t   out_word_r;
  tun_pkg::tun_out_t   out_word_nxt;

  assign adv       = !out_v_r || out_pop;
  assign q_pop     = adv && !q_empty;
  assign out_empty = !out_v_r;
  assign out_word  = out_word_r;

  assign or_mag = x0_r.mag[0] | x0_r.mag[1] | x0_r.mag[2];

  always_comb begin
    priority if (or_mag[MW-1]) begin
      shift_amt = 2'd3;
    end else if (or_mag[MW-2]) begin
      shift_amt = 2'd2;
    end else if (or_mag[MW-3]) begin
      shift_amt = 2'd1;
    end else begin
      shift_amt = 2'd0;
    end
    c1_nxt.degen = x0_r.degen;
    c1_nxt.neg   = x0_r.neg;
    for (int i = 0; i < 3; i++) begin
      c1_nxt.m[i] = KW'(x0_r.mag[i] >> shift_amt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      sv_r[0] <= 1'b0;
    end else if (adv) begin
      v0_r  <= !q_empty;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      sv_r[0] <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x0_r <= q_rdata;
      c1_r <= c1_nxt;
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= QW'(c1_r.m[i]) * QW'(c1_r.m[i]);
      end
      c2_r <= c1_r;
      ss_r[0]   <= SW'(sq_r[0]) + SW'(sq_r[1]) + SW'(sq_r[2]);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sc_r[0]   <= c2_r;
    end
  end

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [XW-1:0] rem2;
    logic [XW-1:0] trial;
    logic          ge;

    assign rem2  = {rem_r[i][XW-3:0], ss_r[i][SW-1 -: 2]};
    assign trial = {1'b0, root_r[i], 2'b01};
    assign ge    = (rem2 >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[i+1] <= 1'b0;
      end else if (adv) begin
        sv_r[i+1] <= sv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        ss_r[i+1]   <= ss_r[i] << 2;
        rem_r[i+1]  <= ge ? rem2 - trial : rem2;
        root_r[i+1] <= {root_r[i][RW-2:0], ge};
        sc_r[i+1]   <= sc_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r[0] <= 1'b0;
    end else if (adv) begin
      dv_r[0] <= sv_r[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dn_r[0][i] <= (NW'(sc_r[RW].m[i]) << (FW + 1)) + NW'(root_r[RW]);
        dq_r[0][i] <= '0;
      end
      dd_r[0] <= {root_r[RW], 1'b0};
      dc_r[0] <= sc_r[RW];
    end
  end

  for (genvar j = 0; j < QTW; j++) begin : g_div
    logic [NW-1:0]  dsh;
    logic [2:0]     ge;

    assign dsh = NW'(dd_r[j]) << (QTW - 1 - j);

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = (dn_r[j][i] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j+1] <= 1'b0;
      end else if (adv) begin
        dv_r[j+1] <= dv_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          dn_r[j+1][i] <= ge[i] ? dn_r[j][i] - dsh : dn_r[j][i];
          dq_r[j+1][i] <= {dq_r[j][i][QTW-2:0], ge[i]};
        end
        dd_r[j+1] <= dd_r[j];
        dc_r[j+1] <= dc_r[j];
      end
    end
  end

  always_comb begin
    logic [2:0][OW-1:0] comp;
    for (int i = 0; i < 3; i++) begin
      comp[i] = dc_r[QTW].neg[i] ? -OW'(dq_r[QTW][i]) : OW'(dq_r[QTW][i]);
      if (dc_r[QTW].degen) comp[i] = '0;
    end
    out_word_nxt.nrm_x      = comp[0];
    out_word_nxt.nrm_y      = comp[1];
    out_word_nxt.nrm_z      = comp[2];
    out_word_nxt.degenerate = dc_r[QTW].degen;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= dv_r[QTW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_word_r <= out_word_nxt;
  end

endmodule
`default_nettype wire

/* verif/tb.sv */
`timescale 1ns / 100ps
module tb;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  tun_pkg::tun_in_t in_word;
  logic out_empty;
  logic out_pop;
  tun_pkg::tun_out_t out_word;

  triangle_unit_normal_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_word(in_word),
    .out_empty(out_empty), .out_pop(out_pop), .out_word(out_word)
  );

  tun_pkg::tun_in_t  tri_queue[$];
  tun_pkg::tun_out_t normal_queue[$];
  int mismatches = 0;
  int hold_cycles = 0;
  int push_wait = 0;
  int pop_wait = 0;
  bit stim_done = 0;
  bit in_taken = 0;
  bit out_taken = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic tun_pkg::tun_out_t face_normal(tun_pkg::tun_in_t t);
    tun_pkg::tun_out_t r;
    logic signed [16:0] e0x, e0y, e0z, e1x, e1y, e1z;
    logic signed [35:0] n [3];
    logic [34:0] mg [3];
    logic [63:0] m [3];
    logic [63:0] s, len, q, lo, hi, mid;
    int w, k;
    e0x = 17'(t.ax) - 17'(t.cx);
    e0y = 17'(t.ay) - 17'(t.cy);
    e0z = 17'(t.az) - 17'(t.cz);
    e1x = 17'(t.bx) - 17'(t.cx);
    e1y = 17'(t.by_coord) - 17'(t.cy);
    e1z = 17'(t.bz) - 17'(t.cz);
    n[0] = 36'(e0y) * 36'(e1z) - 36'(e0z) * 36'(e1y);
    n[1] = 36'(e0z) * 36'(e1x) - 36'(e0x) * 36'(e1z);
    n[2] = 36'(e0x) * 36'(e1y) - 36'(e0y) * 36'(e1x);
    w = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = n[i] < 0 ? 35'(-n[i]) : 35'(n[i]);
      for (int b = 0; b < 35; b++) begin
        if (mg[i][b] && b + 1 > w) w = b + 1;
      end
    end
    r = '0;
    if (w == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    k = w > 30 ? w - 30 : 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = 64'(mg[i] >> k);
      s += m[i] * m[i];
    end
    lo = 0;
    hi = 64'd2147483648;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid;
    end
    len = lo;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 15) + len) / (len * 2);
      if (i == 0) r.nrm_x = n[i] < 0 ? -16'(q) : 16'(q);
      if (i == 1) r.nrm_y = n[i] < 0 ? -16'(q) : 16'(q);
      if (i == 2) r.nrm_z = n[i] < 0 ? -16'(q) : 16'(q);
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_coord(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 63)) - 16'd32;
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 4095)) - 16'd2048;
    endcase
  endfunction

  initial begin
    tun_pkg::tun_in_t t;
    int mode;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_word = '0;
    out_pop = 1'b0;
    t = '0;
    tri_queue = {tri_queue, t};
    t = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h0, 16'h0, 16'h0};
    tri_queue = {tri_queue, t};
    t = '{16'h7fff, 16'h0, 16'h0, 16'h0, 16'h7fff, 16'h0, 16'h8000, 16'h8000, 16'h0};
    tri_queue = {tri_queue, t};
    t = '{16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff,
          16'h7fff};
    tri_queue = {tri_queue, t};
    t = '{16'h10, 16'h0, 16'h0, 16'h0, 16'h10, 16'h0, 16'h0, 16'h0, 16'h0};
    tri_queue = {tri_queue, t};
    t = '{16'h0, 16'h0, 16'h10, 16'h0, 16'h10, 16'h0, 16'h0, 16'h0, 16'h0};
    tri_queue = {tri_queue, t};
    t = '{16'h1, 16'h1, 16'h1, 16'h2, 16'h2, 16'h2, 16'h3, 16'h3, 16'h3};
    tri_queue = {tri_queue, t};
    t = '{16'h7fff, 16'h1, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
    tri_queue = {tri_queue, t};
    t = '{16'h1, 16'h0, 16'h0, 16'h0, 16'h1, 16'h0, 16'h0, 16'h0, 16'h0};
    tri_queue = {tri_queue, t};
    t = '{16'h5, 16'h5, 16'h5, 16'h5, 16'h5, 16'h5, 16'h5, 16'h5, 16'h5};
    tri_queue = {tri_queue, t};
    t = '{16'h7fff, 16'h7fff, 16'h0, 16'h7ffe, 16'h8000, 16'h1, 16'h8000, 16'h7fff, 16'h7fff};
    tri_queue = {tri_queue, t};
    t = '{16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff};
    tri_queue = {tri_queue, t};
    for (int i = 0; i < 1400; i++) begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 19) == 0) begin
        t.ax = rand_coord(mode);
        t.ay = rand_coord(mode);
        t.az = rand_coord(mode);
        t.cx = rand_coord(mode);
        t.cy = rand_coord(mode);
        t.cz = rand_coord(mode);
        t.bx = t.cx + (t.cx - t.ax);
        t.by_coord = t.cy + (t.cy - t.ay);
        t.bz = t.cz + (t.cz - t.az);
      end else begin
        t = '{rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
              rand_coord(mode)};
      end
      tri_queue = {tri_queue, t};
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  always @(posedge clk) begin
    in_taken <= rst_n && in_push && !in_full;
    out_taken <= rst_n && out_pop && !out_empty;
    if (rst_n && in_push && !in_full) begin
      normal_queue = {normal_queue, face_normal(in_word)};
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        void'(tri_queue.pop_front());
        push_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (tri_queue.size() == 0) begin
          in_push <= 1'b0;
          stim_done <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
          in_word <= tri_queue[0];
        end else begin
          in_push <= 1'b0;
        end
      end else if (!in_push && tri_queue.size() != 0) begin
        if (push_wait == 0) begin
          in_push <= 1'b1;
          in_word <= tri_queue[0];
        end else begin
          push_wait <= push_wait - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (normal_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_word);
      end else begin
        if (out_word !== normal_queue[0]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %h actual %h", normal_queue[0], out_word);
          end
        end
        void'(normal_queue.pop_front());
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else if (tri_queue.size() < 1000 && tri_queue.size() > 990 && hold_cycles == 0) begin
      hold_cycles <= 200;
      out_pop <= 1'b0;
    end else if (hold_cycles > 1) begin
      hold_cycles <= hold_cycles - 1;
      out_pop <= 1'b0;
    end else if (out_taken) begin
      pop_wait <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      out_pop <= $urandom_range(0, 3) == 0;
    end else if (!out_pop) begin
      if (pop_wait == 0) out_pop <= 1'b1;
      else pop_wait <= pop_wait - 1;
    end
  end

  initial begin
    wait (stim_done && normal_queue.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && normal_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
